FILE: rtl/chebyshev_series_eval_macros.svh
// ----------------------------------------------------------------------------
// Chebyshev series evaluator assertion macros
// Shared property forms for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef CHEBYSHEV_SERIES_EVAL_MACROS_SVH
`define CHEBYSHEV_SERIES_EVAL_MACROS_SVH

// same-cycle implication, disabled in reset
`define CSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cse assertion failed");

// next-cycle implication, disabled in reset
`define CSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cse assertion failed");

`endif

FILE: rtl/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg
// Types, constants and saturation helpers of the Chebyshev series evaluator.
// ----------------------------------------------------------------------------
`default_nettype none
package cse_pkg;

    localparam int DATA_W        = 32;
    localparam int ACC_W         = 48;
    localparam int FRAC_W        = 24;
    localparam int SUM_W         = 60;
    localparam int PROD_W        = 58;
    localparam int CNT_W         = 6;
    localparam int IDX_W         = 5;
    localparam int MAX_TERMS_DEF = 32;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACC,
        ST_FIN_LO,
        ST_FIN_HI,
        ST_FIN_ACC
    } t_state;

    typedef struct packed {
        logic                     load;
        logic                     shift;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] data;
    } t_cell_ctl;

    localparam logic signed [SUM_W-1:0] ACC_HI = (60'sd1 <<< (ACC_W - 1)) - 60'sd1;
    localparam logic signed [SUM_W-1:0] ACC_LO = -(60'sd1 <<< (ACC_W - 1));
    localparam logic signed [SUM_W-1:0] OUT_HI = (60'sd1 <<< (DATA_W - 1)) - 60'sd1;
    localparam logic signed [SUM_W-1:0] OUT_LO = -(60'sd1 <<< (DATA_W - 1));

    function automatic logic clip_acc(input logic signed [SUM_W-1:0] v);
        return (v > ACC_HI) || (v < ACC_LO);
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        t = (v > ACC_HI) ? ACC_HI : ((v < ACC_LO) ? ACC_LO : v);
        return t[ACC_W-1:0];
    endfunction

    function automatic logic clip_out(input logic signed [SUM_W-1:0] v);
        return (v > OUT_HI) || (v < OUT_LO);
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        t = (v > OUT_HI) ? OUT_HI : ((v < OUT_LO) ? OUT_LO : v);
        return t[DATA_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/chebyshev_series_eval.sv
// ----------------------------------------------------------------------------
// chebyshev_series_eval
// Clenshaw evaluation of a Chebyshev series over a rotating coefficient row.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken when start is high and busy is low.
//   op = load writes coeff_value into entry coeff_index in that same edge and
//   leaves busy low, so loads may follow back to back; indexes at or above
//   MAX_TERMS are dropped. op = evaluate captures x_value and raises busy.
//   The configuration channel (o_cfg_ready always high) writes term_count.
//   An evaluation rotates the coefficient row once, one coefficient per cycle
//   while no recurrence step holds the rotation; each recurrence step uses the
//   shared multiplier (low half, high half, accumulate), and the final multiply
//   uses it once more. The result shows with o_strobe for one cycle, in the
//   same cycle that busy falls; the receiver cannot stall it.
//   Reset clears control state and sets term_count to 1; the coefficient
//   entries stay undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none
`include "chebyshev_series_eval_macros.svh"
module chebyshev_series_eval #(
    parameter int MAX_TERMS = cse_pkg::MAX_TERMS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               i_op,
    input  wire logic [cse_pkg::IDX_W-1:0]          i_coeff_index,
    input  wire logic signed [cse_pkg::DATA_W-1:0]  i_coeff_value,
    input  wire logic signed [cse_pkg::DATA_W-1:0]  i_x_value,
    output logic                                    o_strobe,
    output logic signed [cse_pkg::DATA_W-1:0]       o_series_value,
    output logic                                    o_saturated,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [cse_pkg::CNT_W-1:0]          i_cfg_data
);

    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int NW = (CW > cse_pkg::CNT_W) ? CW : cse_pkg::CNT_W;
    localparam int PW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int FW = cse_pkg::FRAC_W;

    cse_pkg::t_state r_state, n_state;
    logic [PW-1:0]                           r_pos, n_pos;
    logic [NW-1:0]                           r_n, n_n;
    logic [cse_pkg::CNT_W-1:0]               r_term_count;
    logic signed [cse_pkg::DATA_W-1:0]       r_x, n_x;
    logic signed [cse_pkg::DATA_W-1:0]       r_c, n_c;
    logic signed [cse_pkg::ACC_W-1:0]        r_b0, n_b0, r_b1, n_b1;
    logic signed [cse_pkg::PROD_W-1:0]       r_plo, n_plo;
    logic                                    r_clip, n_clip;
    logic signed [cse_pkg::DATA_W-1:0]       r_res, n_res;
    logic                                    r_sat, n_sat;
    logic                                    r_strobe, n_strobe;

    logic                                    accept, eval_acc, rot, last;
    logic                                    skip, top1, top2;
    logic [NW:0]                             jx, nx;
    logic [NW-1:0]                           tc_ext;
    logic signed [cse_pkg::DATA_W-1:0]       tap;
    logic signed [cse_pkg::DATA_W-1:0]       cell_val [MAX_TERMS];
    cse_pkg::t_cell_ctl                      cell_ctl;
    logic signed [24:0]                      mul_a;
    logic signed [32:0]                      mul_m;
    logic signed [cse_pkg::PROD_W-1:0]       mul_p;
    logic signed [cse_pkg::SUM_W-1:0]        prod, d0, d1;

    assign busy        = (r_state != cse_pkg::ST_IDLE);
    assign accept      = start && !busy;
    assign eval_acc    = accept && (i_op == cse_pkg::OP_EVAL);
    assign o_cfg_ready = 1'b1;
    assign tap         = cell_val[MAX_TERMS-1];
    assign last        = (r_pos == '0);

    // classify the coefficient at the tap against the term count
    assign jx   = (NW+1)'(r_pos);
    assign nx   = (NW+1)'(r_n);
    assign skip = (jx >= nx);
    assign top1 = ((jx + (NW+1)'(1)) == nx);
    assign top2 = ((jx + (NW+1)'(2)) == nx);
    assign rot  = ((r_state == cse_pkg::ST_SCAN) && (skip || top1 || top2))
                  || (r_state == cse_pkg::ST_ACC);

    assign tc_ext = NW'(r_term_count);

    assign cell_ctl.load  = accept && (i_op == cse_pkg::OP_LOAD);
    assign cell_ctl.shift = rot;
    assign cell_ctl.idx   = i_coeff_index;
    assign cell_ctl.data  = i_coeff_value;

    genvar k;
    generate
        for (k = 0; k < MAX_TERMS; k++) begin : g_cell
            if (k == 0) begin : g_head
                cse_cell #(.CELL_ID(k)) u_cell (
                    .i_clk   (i_clk),
                    .i_ctl   (cell_ctl),
                    .i_prev  (cell_val[MAX_TERMS-1]),
                    .o_value (cell_val[k])
                );
            end else begin : g_body
                cse_cell #(.CELL_ID(k)) u_cell (
                    .i_clk   (i_clk),
                    .i_ctl   (cell_ctl),
                    .i_prev  (cell_val[k-1]),
                    .o_value (cell_val[k])
                );
            end
        end
    endgenerate

    // multiplier operands: low half of b1 unsigned, then high half signed
    always_comb begin
        if ((r_state == cse_pkg::ST_MUL_LO) || (r_state == cse_pkg::ST_FIN_LO)) begin
            mul_a = $signed({1'b0, r_b1[FW-1:0]});
        end else begin
            mul_a = $signed({r_b1[cse_pkg::ACC_W-1], r_b1[cse_pkg::ACC_W-1:FW]});
        end
        if ((r_state == cse_pkg::ST_MUL_LO) || (r_state == cse_pkg::ST_MUL_HI)) begin
            mul_m = $signed({r_x, 1'b0});
        end else begin
            mul_m = 33'(r_x);
        end
    end

    cse_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_m   (mul_m),
        .o_p   (mul_p)
    );

    assign prod = cse_pkg::SUM_W'(mul_p) + cse_pkg::SUM_W'(r_plo >>> FW);
    assign d0   = cse_pkg::SUM_W'(r_c) - cse_pkg::SUM_W'(r_b1);
    assign d1   = cse_pkg::SUM_W'(r_b0) + prod;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cse_pkg::ST_IDLE:    if (eval_acc) n_state = cse_pkg::ST_SCAN;
            cse_pkg::ST_SCAN: begin
                if (rot) begin
                    n_state = last ? cse_pkg::ST_FIN_LO : cse_pkg::ST_SCAN;
                end else begin
                    n_state = cse_pkg::ST_MUL_LO;
                end
            end
            cse_pkg::ST_MUL_LO:  n_state = cse_pkg::ST_MUL_HI;
            cse_pkg::ST_MUL_HI:  n_state = cse_pkg::ST_ACC;
            cse_pkg::ST_ACC:     n_state = last ? cse_pkg::ST_FIN_LO : cse_pkg::ST_SCAN;
            cse_pkg::ST_FIN_LO:  n_state = cse_pkg::ST_FIN_HI;
            cse_pkg::ST_FIN_HI:  n_state = cse_pkg::ST_FIN_ACC;
            cse_pkg::ST_FIN_ACC: n_state = cse_pkg::ST_IDLE;
            default:             n_state = cse_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_pos    = r_pos;
        n_n      = r_n;
        n_x      = r_x;
        n_c      = r_c;
        n_b0     = r_b0;
        n_b1     = r_b1;
        n_plo    = r_plo;
        n_clip   = r_clip;
        n_res    = r_res;
        n_sat    = r_sat;
        n_strobe = 1'b0;
        if (rot && !last) begin
            n_pos = r_pos - PW'(1);
        end
        case (r_state)
            cse_pkg::ST_IDLE: begin
                if (eval_acc) begin
                    n_x    = i_x_value;
                    n_n    = (tc_ext > NW'(MAX_TERMS)) ? NW'(MAX_TERMS) : tc_ext;
                    n_pos  = PW'(MAX_TERMS - 1);
                    n_b0   = '0;
                    n_b1   = '0;
                    n_clip = 1'b0;
                end
            end
            cse_pkg::ST_SCAN: begin
                if (skip) begin
                    n_c = r_c;
                end else if (top1) begin
                    // a single term goes straight to b0
                    if (r_n == NW'(1)) begin
                        n_b0 = cse_pkg::ACC_W'(tap);
                    end else begin
                        n_b1 = cse_pkg::ACC_W'(tap);
                    end
                end else if (top2) begin
                    n_b0 = cse_pkg::ACC_W'(tap);
                end else begin
                    n_c = tap;
                end
            end
            cse_pkg::ST_MUL_HI,
            cse_pkg::ST_FIN_HI: begin
                n_plo = mul_p;
            end
            cse_pkg::ST_ACC: begin
                n_b0   = cse_pkg::sat_acc(d0);
                n_b1   = cse_pkg::sat_acc(d1);
                n_clip = r_clip || cse_pkg::clip_acc(d0) || cse_pkg::clip_acc(d1);
            end
            cse_pkg::ST_FIN_ACC: begin
                n_res    = cse_pkg::sat_out(d1);
                n_sat    = r_clip || cse_pkg::clip_out(d1);
                n_strobe = 1'b1;
            end
            default: begin
                n_c = r_c;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= cse_pkg::ST_IDLE;
            r_strobe     <= 1'b0;
            r_term_count <= cse_pkg::CNT_W'(1);
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_term_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_n    <= n_n;
        r_x    <= n_x;
        r_c    <= n_c;
        r_b0   <= n_b0;
        r_b1   <= n_b1;
        r_plo  <= n_plo;
        r_clip <= n_clip;
        r_res  <= n_res;
        r_sat  <= n_sat;
    end

    assign o_strobe       = r_strobe;
    assign o_series_value = r_res;
    assign o_saturated    = r_sat;

    `CSE_ASSERT_IMP(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy)
    `CSE_ASSERT_NXT(a_eval_busy, i_clk, i_rst_n, eval_acc, busy)
    `CSE_ASSERT_NXT(a_fin_strobe, i_clk, i_rst_n, r_state == cse_pkg::ST_FIN_ACC, o_strobe)

endmodule
`default_nettype wire

FILE: rtl/cse_cell.sv
// ----------------------------------------------------------------------------
// cse_cell
// One coefficient cell of the rotating table: loads by index, shifts on.
// ----------------------------------------------------------------------------
`default_nettype none
module cse_cell #(
    parameter int CELL_ID = 0
) (
    input  wire logic                              i_clk,
    input  wire cse_pkg::t_cell_ctl                i_ctl,
    input  wire logic signed [cse_pkg::DATA_W-1:0] i_prev,
    output logic signed [cse_pkg::DATA_W-1:0]      o_value
);

    logic signed [cse_pkg::DATA_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_value <= i_prev;
        end else if (i_ctl.load && (32'(i_ctl.idx) == CELL_ID)) begin
            r_value <= i_ctl.data;
        end
    end

    assign o_value = r_value;

endmodule
`default_nettype wire

FILE: rtl/cse_mul.sv
// ----------------------------------------------------------------------------
// cse_mul
// Registered 25 x 33 signed multiplier shared by all recurrence steps.
// ----------------------------------------------------------------------------
`default_nettype none
module cse_mul (
    input  wire logic                              i_clk,
    input  wire logic signed [24:0]                i_a,
    input  wire logic signed [32:0]                i_m,
    output logic signed [cse_pkg::PROD_W-1:0]      o_p
);

    logic signed [cse_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_m;
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

FILE: bench/chebyshev_series_eval_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chebyshev_series_eval_checker
// Watches the command, configuration and result channels of the Chebyshev
// series evaluator, predicts each series value by a Clenshaw recurrence of
// its own and compares every strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module chebyshev_series_eval_checker (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_start,
    input  logic                                       i_busy,
    input  logic                                       i_op,
    input  logic [cse_pkg::IDX_W-1:0]                  i_coeff_index,
    input  logic signed [cse_pkg::DATA_W-1:0]          i_coeff_value,
    input  logic signed [cse_pkg::DATA_W-1:0]          i_x_value,
    input  logic                                       i_strobe,
    input  logic signed [cse_pkg::DATA_W-1:0]          i_series_value,
    input  logic                                       i_saturated,
    input  logic                                       i_cfg_valid,
    input  logic                                       i_cfg_ready,
    input  logic [cse_pkg::CNT_W-1:0]                  i_cfg_data,
    output int                                         o_fail_count,
    output int                                         o_pending
);

    localparam int TABLE_DEPTH = cse_pkg::MAX_TERMS_DEF;

    typedef struct {
        logic signed [cse_pkg::DATA_W-1:0] value;
        logic                              clipped;
    } t_series_result;

    longint                    coef_mem [TABLE_DEPTH];
    logic [cse_pkg::CNT_W-1:0] terms_in_use;
    t_series_result            series_q [$];

    task automatic report_mismatch(input string what);
        $display("%0t: series result mismatch: %s", $time, what);
        o_fail_count = o_fail_count + 1;
    endtask

    // clip to a signed range of the given width, noting any clipping
    function automatic longint clamp_signed(input longint v, input int bits,
                                            inout logic hit);
        longint hi, lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            hit = 1'b1;
            return hi;
        end
        if (v < lo) begin
            hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // exact product, rounded toward minus infinity to Q.24
    function automatic longint floor_product(input longint a, input longint m);
        logic signed [127:0] p, q;
        p = a;
        q = m;
        p = p * q;
        return longint'(p >>> cse_pkg::FRAC_W);
    endfunction

    function automatic t_series_result clenshaw_eval(
        input logic signed [cse_pkg::DATA_W-1:0] x);
        t_series_result res;
        int     n;
        longint xv, b0, b1, keep;
        logic   hit;
        hit = 1'b0;
        xv  = x;
        n   = (terms_in_use > TABLE_DEPTH) ? TABLE_DEPTH : int'(terms_in_use);
        res.value   = '0;
        res.clipped = 1'b0;
        if (n == 0)
            return res;
        b0 = coef_mem[0];
        b1 = 0;
        if (n == 2)
            b1 = coef_mem[1];
        if (n > 2) begin
            b0 = coef_mem[n-2];
            b1 = coef_mem[n-1];
            for (int i = 3; i <= n; i++) begin
                keep = b0;
                b0 = clamp_signed(coef_mem[n-i] - b1, cse_pkg::ACC_W, hit);
                b1 = clamp_signed(keep + floor_product(b1, 2 * xv), cse_pkg::ACC_W, hit);
            end
        end
        res.value   = cse_pkg::DATA_W'(clamp_signed(b0 + floor_product(b1, xv),
                                                    cse_pkg::DATA_W, hit));
        res.clipped = hit;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_series_result want;
        if (!i_rst_n) begin
            terms_in_use <= cse_pkg::CNT_W'(1);
            series_q.delete();
        end else begin
            if (i_strobe) begin
                if (series_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", i_series_value));
                end else begin
                    want = series_q.pop_front();
                    if (i_series_value !== want.value)
                        report_mismatch($sformatf("value %h, want %h",
                                                  i_series_value, want.value));
                    if (i_saturated !== want.clipped)
                        report_mismatch($sformatf("saturated %b, want %b",
                                                  i_saturated, want.clipped));
                end
            end
            // evaluate with the term count in force before this edge
            if (i_start && !i_busy) begin
                if (i_op == cse_pkg::OP_EVAL)
                    series_q = {series_q, clenshaw_eval(i_x_value)};
                else
                    coef_mem[i_coeff_index] = i_coeff_value;
            end
            if (i_cfg_valid && i_cfg_ready)
                terms_in_use <= i_cfg_data;
        end
        o_pending <= series_q.size();
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives coefficient loads, evaluations and term count writes into the
// Chebyshev series evaluator; the checker beside it predicts and compares.
// ----------------------------------------------------------------------------
module tb;

    localparam int TABLE_DEPTH = cse_pkg::MAX_TERMS_DEF;
    localparam int SETTLE      = 140;
    localparam int STALL_LIMIT = 20000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 225;

    logic                              i_clk         = 1'b0;
    logic                              i_rst_n       = 1'b0;
    logic                              start         = 1'b0;
    logic                              i_op          = cse_pkg::OP_LOAD;
    logic [cse_pkg::IDX_W-1:0]         i_coeff_index = '0;
    logic signed [cse_pkg::DATA_W-1:0] i_coeff_value = '0;
    logic signed [cse_pkg::DATA_W-1:0] i_x_value     = '0;
    logic                              i_cfg_valid   = 1'b0;
    logic [cse_pkg::CNT_W-1:0]         i_cfg_data    = '0;
    logic                              busy;
    logic                              o_strobe;
    logic signed [cse_pkg::DATA_W-1:0] o_series_value;
    logic                              o_saturated;
    logic                              o_cfg_ready;
    int                                fail_count;
    int                                pending;
    int                                quiet_cycles = 0;

    logic                              loaded [TABLE_DEPTH];
    int                                term_setting = 1;
    bit                                no_idle      = 1'b0;

    chebyshev_series_eval dut (
        .i_clk, .i_rst_n, .start, .busy, .i_op, .i_coeff_index, .i_coeff_value,
        .i_x_value, .o_strobe, .o_series_value, .o_saturated,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_data
    );

    chebyshev_series_eval_checker checker_u (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_op, .i_coeff_index,
        .i_coeff_value, .i_x_value, .i_strobe(o_strobe),
        .i_series_value(o_series_value), .i_saturated(o_saturated),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("chebyshev_series_eval: mismatch");
            $finish;
        end
    end

    function automatic logic signed [cse_pkg::DATA_W-1:0] rand_coeff();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return cse_pkg::DATA_W'($signed($urandom_range(0, 2**25)) - 2**24);
        if (pick < 85)
            return cse_pkg::DATA_W'($signed($urandom_range(0, 2**27)) - 2**26);
        return $urandom;
    endfunction

    function automatic logic signed [cse_pkg::DATA_W-1:0] rand_point();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return cse_pkg::DATA_W'($signed($urandom_range(0, 2**25)) - 2**24);
        if (pick < 80)
            return (pick < 74) ? 32'sh0100_0000 : ((pick < 77) ? -32'sh0100_0000 : '0);
        return $urandom;
    endfunction

    task automatic send_item(input logic op, input logic [cse_pkg::IDX_W-1:0] idx,
                             input logic signed [cse_pkg::DATA_W-1:0] cval,
                             input logic signed [cse_pkg::DATA_W-1:0] xval);
        int gap;
        gap = (!no_idle && $urandom_range(99) < 9) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_op          <= op;
        i_coeff_index <= idx;
        i_coeff_value <= cval;
        i_x_value     <= xval;
        start         <= 1'b1;
        if (op == cse_pkg::OP_LOAD)
            loaded[idx] = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // drain all results, let trailing work settle, then write term_count
    task automatic write_terms(input int value);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_data  <= cse_pkg::CNT_W'(value);
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid  <= 1'b0;
        term_setting = value;
    endtask

    // evaluate only when every entry in use was loaded; otherwise fill a hole
    task automatic random_item();
        int n, hole;
        n = (term_setting > TABLE_DEPTH) ? TABLE_DEPTH : term_setting;
        hole = -1;
        for (int i = n - 1; i >= 0; i--)
            if (!loaded[i]) hole = i;
        if (hole >= 0)
            send_item(cse_pkg::OP_LOAD, cse_pkg::IDX_W'(hole), rand_coeff(), $urandom);
        else if ($urandom_range(99) < 55)
            send_item(cse_pkg::OP_EVAL, cse_pkg::IDX_W'($urandom), $urandom, rand_point());
        else if (n > 0 && $urandom_range(99) < 85)
            send_item(cse_pkg::OP_LOAD, cse_pkg::IDX_W'($urandom_range(0, n - 1)),
                      rand_coeff(), $urandom);
        else
            send_item(cse_pkg::OP_LOAD, cse_pkg::IDX_W'($urandom), rand_coeff(), $urandom);
    endtask

    initial begin
        int phase_terms [PHASES];
        for (int i = 0; i < TABLE_DEPTH; i++)
            loaded[i] = 1'b0;
        phase_terms = '{0, 32, 63, 2, 3, 1, 0, 0};
        phase_terms[6] = $urandom_range(0, 63);
        phase_terms[7] = $urandom_range(4, 31);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single term at reset: value is c0, extremes of the fields
        send_item(cse_pkg::OP_LOAD, 5'd0, 32'sh7FFF_FFFF, 32'sh0);
        send_item(cse_pkg::OP_EVAL, 5'd31, 32'sh0, 32'sh0);
        send_item(cse_pkg::OP_LOAD, 5'd0, -32'sh8000_0000, 32'shFFFF_FFFF);
        send_item(cse_pkg::OP_EVAL, 5'd0, 32'shFFFF_FFFF, 32'sh7FFF_FFFF);
        send_item(cse_pkg::OP_EVAL, 5'd0, 32'sh0, -32'sh8000_0000);
        send_item(cse_pkg::OP_LOAD, 5'd31, 32'sh0100_0000, 32'sh0);
        send_item(cse_pkg::OP_LOAD, 5'd1, 32'sh7FFF_FFFF, 32'sh0);
        send_item(cse_pkg::OP_LOAD, 5'd2, -32'sh8000_0000, 32'sh0);
        send_item(cse_pkg::OP_LOAD, 5'd3, 32'sh0100_0000, 32'sh0);
        write_terms(2);
        send_item(cse_pkg::OP_EVAL, 5'd0, 32'sh0, 32'sh7FFF_FFFF);
        send_item(cse_pkg::OP_EVAL, 5'd0, 32'sh0, 32'sh0100_0000);
        write_terms(4);
        send_item(cse_pkg::OP_EVAL, 5'd0, 32'sh0, 32'sh7FFF_FFFF);
        send_item(cse_pkg::OP_EVAL, 5'd0, 32'sh0, -32'sh8000_0000);
        send_item(cse_pkg::OP_EVAL, 5'd0, 32'sh0, 32'sh0080_0000);

        for (int p = 0; p < PHASES; p++) begin
            write_terms(phase_terms[p]);
            no_idle = (p == 3);
            for (int k = 0; k < PHASE_ITEMS; k++)
                random_item();
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0)
            $display("chebyshev_series_eval: match");
        else
            $display("chebyshev_series_eval: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/cse_pkg.sv
rtl/cse_cell.sv
rtl/cse_mul.sv
rtl/chebyshev_series_eval.sv
bench/chebyshev_series_eval_checker.sv
bench/tb.sv
